// ----- rtl/bfs_pkg.sv -----
// Shared types and constants for the streaming box filter sum.
package bfs_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int SUM_BITS      = 26;
    localparam int HEIGHT_BITS   = 11;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS       = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0]   RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [3:0]               RST_RADIUS       = 4'd1;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] window_sum;
        logic                       frame_last;
    } t_out_item;

endpackage

// ----- rtl/bfs_queue.sv -----
// Small register queue between the front and back parts.
module bfs_queue #(
    parameter type t_op  = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_op  o_data,
    input  logic i_pop
);
    localparam int AW = $clog2(DEPTH);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           push_ok;
    logic           pop_ok;

    assign o_ready = (r_cnt < (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
        end
    end

endmodule

// ----- rtl/bfs_front.sv -----
// Front part: configuration, frame position tracking and item classification.
module bfs_front #(
    parameter type t_op       = logic,
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_RADIUS = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [bfs_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [bfs_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                  o_cfg_ready,
    input  logic                                  i_in_valid,
    input  bfs_pkg::t_in_item                     i_in_item,
    output logic                                  o_in_ready,
    output logic                                  o_push,
    output t_op                                   o_op,
    input  logic                                  i_q_ready
);
    import bfs_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = XW + 1;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int ROWS = 2 * MAX_RADIUS + 2;
    localparam int SW   = $clog2(ROWS);
    localparam int PW   = WW + HEIGHT_BITS + 1;
    localparam int IYW  = HEIGHT_BITS + 1;

    logic [CFG_DATA_BITS-1:0] r_frame_width;
    logic [HEIGHT_BITS-1:0]   r_frame_height;
    logic [3:0]               r_radius;

    logic [PW-1:0]  r_p;
    logic [XW-1:0]  r_ix;
    logic [IYW-1:0] r_iy;
    logic [SW-1:0]  r_ws;
    logic [XW-1:0]  r_ox;

    logic [WW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [RW-1:0]          r_eff;
    logic [RW:0]            span;
    logic [PW-1:0]          total;
    logic [PW-1:0]          lag;
    logic [PW-1:0]          orw;
    logic [SW:0]            rs_sum;
    logic [SW-1:0]          rd_slot;
    logic                   is_sample;
    logic                   emit;
    logic                   last;
    logic                   row_end;
    logic                   accept;
    logic                   ignore;
    logic                   cfg_hit;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? HEIGHT_BITS'(1) : r_frame_height;
        r_eff = (32'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);
    end

    assign span      = {r_eff, 1'b1};
    assign total     = PW'(w_eff) * PW'(h_eff);
    assign lag       = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    assign is_sample = (r_p < total);
    assign emit      = (r_p >= lag);
    assign last      = emit && ((r_p - lag) == (total - PW'(1)));
    assign row_end   = ({1'b0, r_ix} == (w_eff - WW'(1)));
    assign orw       = PW'(r_ox) + PW'(r_eff);

    // read slot trails the write slot by span rows, modulo the row count
    assign rs_sum  = {1'b0, r_ws} + (SW+1)'(ROWS) - (SW+1)'(span);
    assign rd_slot = (rs_sum >= (SW+1)'(ROWS)) ? SW'(rs_sum - (SW+1)'(ROWS)) : SW'(rs_sum);

    assign accept      = i_in_valid && o_in_ready;
    assign ignore      = (i_in_item.kind == KIND_DRAIN) && is_sample;
    assign o_in_ready  = i_q_ready;
    assign o_cfg_ready = 1'b1;
    assign o_push      = accept && !ignore;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_FRAME_WIDTH ||
                         i_cfg_index == CFG_FRAME_HEIGHT || i_cfg_index == CFG_RADIUS);

    always_comb begin
        o_op           = '0;
        o_op.is_sample = is_sample;
        o_op.sample    = i_in_item.sample;
        o_op.ix        = r_ix;
        o_op.ix0       = (r_ix == '0);
        o_op.iy0       = (r_iy == '0);
        o_op.has_old   = (r_iy >= IYW'(span));
        o_op.wr_slot   = r_ws;
        o_op.rd_slot   = rd_slot;
        o_op.emit      = emit;
        o_op.last      = last;
        o_op.ridx      = (orw < PW'(w_eff)) ? '0 : SW'(orw - PW'(w_eff) + PW'(1));
        o_op.lidx      = SW'(span);
        o_op.left_en   = (PW'(r_ox) > PW'(r_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_radius       <= RST_RADIUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= HEIGHT_BITS'(i_cfg_data);
                end
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_ix <= '0;
            r_iy <= '0;
            r_ws <= '0;
            r_ox <= '0;
        end else if (cfg_hit || (o_push && last)) begin
            // restart the frame
            r_p  <= '0;
            r_ix <= '0;
            r_iy <= '0;
            r_ws <= '0;
            r_ox <= '0;
        end else if (o_push) begin
            r_p <= r_p + PW'(1);
            if (row_end) begin
                r_ix <= '0;
                r_iy <= r_iy + IYW'(1);
                r_ws <= (r_ws == SW'(ROWS - 1)) ? '0 : r_ws + SW'(1);
            end else begin
                r_ix <= r_ix + XW'(1);
            end
            if (emit) begin
                r_ox <= (({1'b0, r_ox}) == (w_eff - WW'(1))) ? '0 : r_ox + XW'(1);
            end
        end
    end

endmodule

// ----- rtl/bfs_back.sv -----
// Back part: column running sums, row prefix taps and window sum output.
module bfs_back #(
    parameter type t_op       = logic,
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_RADIUS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_op                i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output bfs_pkg::t_out_item o_out_item,
    input  logic               i_out_ready
);
    import bfs_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int ROWS = 2 * MAX_RADIUS + 2;
    localparam int SW   = $clog2(ROWS);
    localparam int CW   = SAMPLE_BITS + $clog2(2 * MAX_RADIUS + 1);
    localparam int NT   = ROWS;

    logic signed [SAMPLE_BITS-1:0] r_row_mem [ROWS * (2 ** XW)];
    logic signed [CW-1:0]          r_col_mem [2 ** XW];
    logic [SUM_BITS-1:0]           r_taps    [NT];

    logic                          adv;
    logic                          r_b1_v;
    logic                          r_b2_v;
    logic                          r_b3_v;
    t_op                           r_b1;
    t_op                           r_b2;
    t_op                           r_b3;
    logic signed [CW-1:0]          r_colrd;
    logic signed [SAMPLE_BITS-1:0] r_oldrd;
    logic                          r_fwd;
    logic signed [CW-1:0]          r_last_col;
    logic signed [CW-1:0]          r_b2_col;
    logic                          r_out_valid;
    t_out_item                     r_out;

    logic signed [CW-1:0]          col_prev;
    logic signed [CW-1:0]          col_new;
    logic signed [CW-1:0]          val_ext;
    logic signed [CW-1:0]          old_ext;
    logic [SUM_BITS-1:0]           prefix;
    logic [SUM_BITS-1:0]           left_sum;
    logic [SUM_BITS-1:0]           win_sum;

    // the whole back pipeline moves together when the output register can take
    assign adv         = !r_out_valid || i_out_ready;
    assign o_q_pop     = adv && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        col_prev = r_b1.iy0 ? '0 : (r_fwd ? r_last_col : r_colrd);
        val_ext  = r_b1.is_sample ? CW'($signed(r_b1.sample)) : '0;
        old_ext  = r_b1.has_old ? CW'(r_oldrd) : '0;
        col_new  = col_prev + val_ext - old_ext;
        prefix   = (r_b2.ix0 ? '0 : r_taps[0]) + SUM_BITS'(r_b2_col);
        left_sum = r_b3.left_en ? r_taps[r_b3.lidx] : '0;
        win_sum  = r_taps[r_b3.ridx] - left_sum;
    end

    // row delay store: write the new sample, read the one span rows back
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_oldrd <= r_row_mem[{i_q_data.rd_slot, i_q_data.ix}];
            if (i_q_data.is_sample) begin
                r_row_mem[{i_q_data.wr_slot, i_q_data.ix}] <= i_q_data.sample;
            end
        end
    end

    // column running sums
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_colrd <= r_col_mem[i_q_data.ix];
        end
        if (adv && r_b1_v) begin
            r_col_mem[r_b1.ix] <= col_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_q_pop) begin
                r_b1  <= i_q_data;
                // a same-column write lands on this edge: take it from r_last_col
                r_fwd <= r_b1_v && (r_b1.ix == i_q_data.ix);
            end
            if (r_b1_v) begin
                r_last_col <= col_new;
            end
            r_b2     <= r_b1;
            r_b2_col <= col_new;
            r_b3     <= r_b2;
            if (r_b2_v) begin
                r_taps[0] <= prefix;
                for (int k = 1; k < NT; k++) begin
                    r_taps[k] <= r_taps[k-1];
                end
            end
            r_out.window_sum <= win_sum;
            r_out.frame_last <= r_b3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_b3_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b1_v      <= i_q_valid;
            r_b2_v      <= r_b1_v;
            r_b3_v      <= r_b2_v;
            r_out_valid <= r_b3_v && r_b3.emit;
        end
    end

endmodule

// ----- rtl/box_filter_sum_2d.sv -----
// Top level of the streaming two-dimensional box filter sum.
//
// Usage: send one image in raster order on the input channel, one signed
// sample per transfer (kind = sample). After the frame's last pixel, send
// drain transfers (kind = drain) until the result with frame_last arrives;
// results lag the input by radius rows plus radius pixels, so radius*width
// + radius drains are needed. A drain before the frame is complete is
// accepted and dropped; a sample after the frame end acts as a drain.
// Each result is the sum of the clipped (2r+1) x (2r+1) window around one
// pixel, in raster order.
// Throughput: one transfer per clock in both directions while the receiver
// takes results; the front part updates its counters once per item and the
// back part runs a three-stage pipeline with one read and one write per
// memory per cycle and registers its results. A four-entry queue parts
// front and back; when the receiver stalls the back pipeline holds and the
// front keeps taking items until the queue fills. Reset restores width
// 1024, height 1024, radius 1 and restarts the frame; the row store needs
// no clearing. Configuration writes are taken at any time, but are meant
// for an idle block; each write to width, height or radius restarts the frame.
module box_filter_sum_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bfs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bfs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                               o_cfg_ready,
    input  logic                               i_in_valid,
    input  bfs_pkg::t_in_item                  i_in_item,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output bfs_pkg::t_out_item                 o_out_item,
    input  logic                               i_out_ready
);
    import bfs_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(2 * MAX_RADIUS + 2);

    // One classified item on its way from front to back.
    typedef struct packed {
        logic                          is_sample;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [XW-1:0]                 ix;
        logic                          ix0;
        logic                          iy0;
        logic                          has_old;
        logic [SW-1:0]                 wr_slot;
        logic [SW-1:0]                 rd_slot;
        logic                          emit;
        logic                          last;
        logic [SW-1:0]                 ridx;
        logic [SW-1:0]                 lidx;
        logic                          left_en;
    } t_op;

    logic push;
    t_op  push_op;
    logic q_ready;
    logic q_valid;
    t_op  q_op;
    logic q_pop;

    // classify items and track the frame position
    bfs_front #(
        .t_op       (t_op),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_op        (push_op),
        .i_q_ready   (q_ready)
    );

    bfs_queue #(
        .t_op  (t_op),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_pop   (q_pop)
    );

    // vertical and horizontal sums, output register
    bfs_back #(
        .t_op       (t_op),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule
